>>> rtl/core/msp_pkg.sv
// Package for the modular sum-product expression unit.
// Holds field widths, chain lengths and the reset modulus. No dependencies.
`timescale 1ns / 1ps

package msp_pkg;

   localparam int OP_W          = 64;
   localparam int RES_W         = 31;
   localparam int DIV1_W        = OP_W - 1;
   localparam int PROD_W        = 2 * RES_W;
   localparam int OPERAND_LANES = 4;
   localparam int PRODUCT_LANES = 3;

   typedef logic [RES_W-1:0] residue_type;

   localparam residue_type RESET_MODULUS = 31'd1000000007;

endpackage

>>> rtl/core/modular_sum_product_expression_unit.sv
// Top level of the modular sum-product expression unit.
// Depends on msp_pkg and msp_cell.
`timescale 1ns / 1ps

// Computes ((a+b)*(c-d) + (a*c - b*d)) mod m as a residue 0..m-1 from four signed 64-bit
// words, with m taken from the csr port (reset 1000000007; m of zero gives 0). One word is
// accepted per cycle unless a stalled result holds the pipeline. The pipeline is made up of
// two chains of remainder cells, 63 for the operand residues and 62 for the product residues,
// each cell folding one bit per cycle, plus five arithmetic stages.
// A stall on the result side holds the whole pipeline. Write the modulus only while idle.
module modular_sum_product_expression_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic signed [63:0]          req_op_a,
   input  logic signed [63:0]          req_op_b,
   input  logic signed [63:0]          req_op_c,
   input  logic signed [63:0]          req_op_d,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [30:0]                 rsp_residue,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [30:0]                 csr_data
);

   localparam int N1 = msp_pkg::DIV1_W;
   localparam int N2 = msp_pkg::PROD_W;
   localparam int L1 = msp_pkg::OPERAND_LANES;
   localparam int L2 = msp_pkg::PRODUCT_LANES;
   localparam int RW = msp_pkg::RES_W;

   logic                 advance;
   msp_pkg::residue_type modulus_ff;

   logic                            c1_valid [0:N1];
   logic [L1-1:0][RW-1:0]           c1_rem   [0:N1];
   logic [L1-1:0][N1-1:0]           c1_div   [0:N1];
   logic [L1-1:0]                   sign_in;
   logic [L1-1:0]                   sign_ff  [0:N1-1];

   logic                            fix_valid_ff;
   logic [L1-1:0][RW-1:0]           fix_ff, fix_in;
   logic                            sum_valid_ff;
   msp_pkg::residue_type            ra_ff, rb_ff, rc_ff, rd_ff, sab_ff, dcd_ff;
   logic [RW:0]                     sab_t, dcd_t;
   msp_pkg::residue_type            sab_in, dcd_in;

   logic                            c2_valid [0:N2];
   logic [L2-1:0][RW-1:0]           c2_rem   [0:N2];
   logic [L2-1:0][N2-1:0]           c2_div   [0:N2];
   logic                            prod_valid_ff;
   logic [L2-1:0][N2-1:0]           prod_ff;

   logic                            dp_valid_ff;
   msp_pkg::residue_type            main_ff, dp_ff, dp_in;
   logic [RW:0]                     dp_t, out_t;
   msp_pkg::residue_type            out_in;
   logic                            rsp_valid_ff;
   msp_pkg::residue_type            rsp_residue_ff;

   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= msp_pkg::RESET_MODULUS;
      end else if (csr_valid && csr_ready) begin
         modulus_ff <= csr_data;
      end
   end

   // operand chain entry: fold negative words as m-1-((-x-1) mod m)
   assign sign_in   = {req_op_d[63], req_op_c[63], req_op_b[63], req_op_a[63]};
   assign c1_valid[0] = req_valid;
   assign c1_rem[0]   = '0;
   assign c1_div[0][0] = req_op_a[63] ? ~req_op_a[N1-1:0] : req_op_a[N1-1:0];
   assign c1_div[0][1] = req_op_b[63] ? ~req_op_b[N1-1:0] : req_op_b[N1-1:0];
   assign c1_div[0][2] = req_op_c[63] ? ~req_op_c[N1-1:0] : req_op_c[N1-1:0];
   assign c1_div[0][3] = req_op_d[63] ? ~req_op_d[N1-1:0] : req_op_d[N1-1:0];

   always_ff @(posedge clock) begin
      if (advance) begin
         sign_ff[0] <= sign_in;
         for (int i = 1; i < N1; i++) begin
            sign_ff[i] <= sign_ff[i-1];
         end
      end
   end

   for (genvar g = 0; g < N1; g++) begin : g_op_chain
      msp_cell #(.LANES(L1), .DIV_W(N1)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .modulus  (modulus_ff),
         .up_valid (c1_valid[g]),
         .up_rem   (c1_rem[g]),
         .up_div   (c1_div[g]),
         .dn_valid (c1_valid[g+1]),
         .dn_rem   (c1_rem[g+1]),
         .dn_div   (c1_div[g+1])
      );
   end

   always_comb begin
      for (int i = 0; i < L1; i++) begin
         fix_in[i] = sign_ff[N1-1][i] ? RW'(modulus_ff - RW'(1) - c1_rem[N1][i])
                                      : c1_rem[N1][i];
      end
   end

   always_comb begin
      sab_t  = {1'b0, fix_ff[0]} + {1'b0, fix_ff[1]};
      sab_in = (sab_t >= {1'b0, modulus_ff}) ? RW'(sab_t - {1'b0, modulus_ff}) : RW'(sab_t);
      dcd_t  = {1'b0, fix_ff[2]} + {1'b0, RW'(modulus_ff - fix_ff[3])};
      dcd_in = (dcd_t >= {1'b0, modulus_ff}) ? RW'(dcd_t - {1'b0, modulus_ff}) : RW'(dcd_t);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fix_valid_ff  <= 1'b0;
         sum_valid_ff  <= 1'b0;
         prod_valid_ff <= 1'b0;
      end else if (advance) begin
         fix_valid_ff  <= c1_valid[N1];
         sum_valid_ff  <= fix_valid_ff;
         prod_valid_ff <= sum_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         fix_ff     <= fix_in;
         ra_ff      <= fix_ff[0];
         rb_ff      <= fix_ff[1];
         rc_ff      <= fix_ff[2];
         rd_ff      <= fix_ff[3];
         sab_ff     <= sab_in;
         dcd_ff     <= dcd_in;
         prod_ff[0] <= ra_ff * rc_ff;
         prod_ff[1] <= rb_ff * rd_ff;
         prod_ff[2] <= sab_ff * dcd_ff;
      end
   end

   // product chain: lane 0 a*c, lane 1 b*d, lane 2 (a+b)*(c-d)
   assign c2_valid[0] = prod_valid_ff;
   assign c2_rem[0]   = '0;
   assign c2_div[0]   = prod_ff;

   for (genvar g = 0; g < N2; g++) begin : g_prod_chain
      msp_cell #(.LANES(L2), .DIV_W(N2)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .modulus  (modulus_ff),
         .up_valid (c2_valid[g]),
         .up_rem   (c2_rem[g]),
         .up_div   (c2_div[g]),
         .dn_valid (c2_valid[g+1]),
         .dn_rem   (c2_rem[g+1]),
         .dn_div   (c2_div[g+1])
      );
   end

   always_comb begin
      dp_t   = {1'b0, c2_rem[N2][0]} + {1'b0, RW'(modulus_ff - c2_rem[N2][1])};
      dp_in  = (dp_t >= {1'b0, modulus_ff}) ? RW'(dp_t - {1'b0, modulus_ff}) : RW'(dp_t);
      out_t  = {1'b0, main_ff} + {1'b0, dp_ff};
      if (modulus_ff == '0) begin
         out_in = '0;
      end else if (out_t >= {1'b0, modulus_ff}) begin
         out_in = RW'(out_t - {1'b0, modulus_ff});
      end else begin
         out_in = RW'(out_t);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dp_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         dp_valid_ff  <= c2_valid[N2];
         rsp_valid_ff <= dp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         main_ff        <= c2_rem[N2][2];
         dp_ff          <= dp_in;
         rsp_residue_ff <= out_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_residue = rsp_residue_ff;

endmodule

>>> rtl/core/msp_cell.sv
// One remainder cell: takes one dividend bit per lane into a running residue mod m.
// Depends on msp_pkg.
`timescale 1ns / 1ps

module msp_cell #(
   parameter int LANES = msp_pkg::OPERAND_LANES,
   parameter int DIV_W = msp_pkg::DIV1_W
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        advance,
   input  msp_pkg::residue_type                        modulus,
   input  logic                                        up_valid,
   input  logic [LANES-1:0][msp_pkg::RES_W-1:0]        up_rem,
   input  logic [LANES-1:0][DIV_W-1:0]                 up_div,
   output logic                                        dn_valid,
   output logic [LANES-1:0][msp_pkg::RES_W-1:0]        dn_rem,
   output logic [LANES-1:0][DIV_W-1:0]                 dn_div
);

   logic                                 valid_ff;
   logic [LANES-1:0][msp_pkg::RES_W-1:0] rem_ff, rem_in;
   logic [LANES-1:0][DIV_W-1:0]          div_ff, div_in;
   logic [LANES-1:0][msp_pkg::RES_W:0]   trial;

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         trial[i] = {up_rem[i], up_div[i][DIV_W-1]};
         if (trial[i] >= {1'b0, modulus}) begin
            rem_in[i] = msp_pkg::RES_W'(trial[i] - {1'b0, modulus});
         end else begin
            rem_in[i] = trial[i][msp_pkg::RES_W-1:0];
         end
         div_in[i] = {up_div[i][DIV_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff <= rem_in;
         div_ff <= div_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_rem   = rem_ff;
   assign dn_div   = div_ff;

endmodule

>>> rtl/core/msp_checker.sv
// Port-level checker for the modular sum-product expression unit, with its bind.
// Depends on msp_pkg and modular_sum_product_expression_unit.
`timescale 1ns / 1ps

module msp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [30:0] rsp_residue,
   input logic        csr_valid,
   input logic        csr_ready,
   input logic [30:0] csr_data
);

   msp_pkg::residue_type mod_ff;

   // track the modulus as written on the port
   always_ff @(posedge clock) begin
      if (reset) begin
         mod_ff <= msp_pkg::RESET_MODULUS;
      end else if (csr_valid && csr_ready) begin
         mod_ff <= csr_data;
      end
   end

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word valid right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_residue))
      else $error("stalled result word changed");

   a_no_idle_stall: assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && rsp_stall) |-> !req_stall)
      else $error("input stalled while result side is free");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && mod_ff != '0 |-> rsp_residue < mod_ff)
      else $error("residue not below modulus");

   a_zero_mod: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && mod_ff == '0 |-> rsp_residue == '0)
      else $error("nonzero residue with zero modulus");

endmodule

bind modular_sum_product_expression_unit msp_checker u_msp_checker (
   .clock       (clock),
   .reset       (reset),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_residue (rsp_residue),
   .csr_valid   (csr_valid),
   .csr_ready   (csr_ready),
   .csr_data    (csr_data)
);
